@@ sv/gir_pkg.sv @@
// ----------------------------------------------------------------------------
// gir_pkg
// Types, constants and helpers shared by the gamepad input remapper.
// ----------------------------------------------------------------------------
package gir_pkg;

  localparam int NUM_BTN    = 16;
  localparam int NUM_SRC    = 32;
  localparam int NUM_ZONE   = 8;
  localparam int ENTRY_W    = 5;
  localparam int SRC_LSTICK = 24;
  localparam int SRC_RSTICK = 28;
  localparam int STICK_DIRS = 4;

  localparam logic [7:0]  CENTER    = 8'd127;
  localparam logic [10:0] SPLIT_X   = 11'd960;
  localparam logic [10:0] SPLIT_Y   = 11'd544;
  localparam logic [4:0]  PASS_CODE = 5'd16;

  localparam int BTN_SQUARE = 3;
  localparam int BTN_START  = 4;

  localparam logic [59:0] REMAP_LOW_RST  = 60'd407901468851537952;
  localparam logic [59:0] REMAP_MID_RST  = 60'd595056260442208684;
  localparam logic [39:0] REMAP_HIGH_RST = 40'd567489872400;
  localparam logic [6:0]  DEADZONE_RST   = 7'd50;

  localparam logic [2:0] REG_REMAP_LOW  = 3'd0;
  localparam logic [2:0] REG_REMAP_MID  = 3'd1;
  localparam logic [2:0] REG_REMAP_HIGH = 3'd2;
  localparam logic [2:0] REG_LX_DZ      = 3'd3;
  localparam logic [2:0] REG_LY_DZ      = 3'd4;
  localparam logic [2:0] REG_RX_DZ      = 3'd5;
  localparam logic [2:0] REG_RY_DZ      = 3'd6;

  localparam logic ACT_TOUCH = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  typedef struct packed {
    logic        action;
    logic        touch_panel;
    logic [10:0] touch_x;
    logic [10:0] touch_y;
    logic [15:0] button_bits;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic        inverted;
  } in_item_t;

  typedef struct packed {
    logic [15:0] buttons_out;
    logic [7:0]  left_x_out;
    logic [7:0]  left_y_out;
    logic [7:0]  right_x_out;
    logic [7:0]  right_y_out;
    logic        menu_request;
  } out_item_t;

  typedef struct packed {
    logic [59:0] remap_low;
    logic [59:0] remap_mid;
    logic [39:0] remap_high;
    logic [6:0]  left_x_dz;
    logic [6:0]  left_y_dz;
    logic [6:0]  right_x_dz;
    logic [6:0]  right_y_dz;
  } cfg_t;

  // {high side, low side} of one stick axis
  function automatic logic [1:0] axis_dir(input logic [7:0] v, input logic [6:0] dz);
    logic [8:0] lo_sum;
    logic [8:0] hi_lim;
    logic       lo;
    logic       hi;
    lo_sum = {1'b0, v} + {2'b00, dz};
    hi_lim = {1'b0, CENTER} + {2'b00, dz};
    lo     = lo_sum < {1'b0, CENTER};
    hi     = !lo && ({1'b0, v} > hi_lim);
    return {hi, lo};
  endfunction

endpackage

@@ sv/gir_frame_map.sv @@
// ----------------------------------------------------------------------------
// gir_frame_map
// Remaps one frame item: stick directions, 32 remap entries, stick forcing
// and the menu request pass-through.
// ----------------------------------------------------------------------------
module gir_frame_map
  import gir_pkg::*;
(
  input  in_item_t        item,
  input  logic [7:0]      latch,
  input  cfg_t            cfg,
  output out_item_t       res
);

  logic [NUM_SRC*ENTRY_W-1:0] entries;
  logic [15:0]                btn;
  logic [NUM_SRC-1:0]         act;
  logic [15:0]                map;
  logic [ENTRY_W-1:0]         e;
  logic                       l_remap;
  logic                       r_remap;
  logic                       menu;

  always_comb begin
    entries = {cfg.remap_high, cfg.remap_mid, cfg.remap_low};
    btn     = item.inverted ? ~item.button_bits : item.button_bits;
    act     = {axis_dir(item.right_y, cfg.right_y_dz),
               axis_dir(item.right_x, cfg.right_x_dz),
               axis_dir(item.left_y,  cfg.left_y_dz),
               axis_dir(item.left_x,  cfg.left_x_dz),
               latch, btn};
    map = '0;
    e   = '0;
    for (int s = 0; s < NUM_SRC; s++) begin
      e = entries[ENTRY_W*s +: ENTRY_W];
      if (act[s]) begin
        if (e < PASS_CODE) begin
          map[e[3:0]] = 1'b1;
        end else if (e == PASS_CODE && s < NUM_BTN) begin
          map[s[3:0]] = 1'b1;
        end
      end
    end
    l_remap = 1'b0;
    r_remap = 1'b0;
    for (int k = 0; k < STICK_DIRS; k++) begin
      if (entries[ENTRY_W*(SRC_LSTICK+k) +: ENTRY_W] != PASS_CODE) l_remap = 1'b1;
      if (entries[ENTRY_W*(SRC_RSTICK+k) +: ENTRY_W] != PASS_CODE) r_remap = 1'b1;
    end
    menu = btn[BTN_START] && btn[BTN_SQUARE];

    res.menu_request = menu;
    if (menu) begin
      res.buttons_out = item.button_bits;
      res.left_x_out  = item.left_x;
      res.left_y_out  = item.left_y;
      res.right_x_out = item.right_x;
      res.right_y_out = item.right_y;
    end else begin
      res.buttons_out = item.inverted ? ~map : map;
      res.left_x_out  = l_remap ? CENTER : item.left_x;
      res.left_y_out  = l_remap ? CENTER : item.left_y;
      res.right_x_out = r_remap ? CENTER : item.right_x;
      res.right_y_out = r_remap ? CENTER : item.right_y;
    end
  end

endmodule

@@ sv/gamepad_input_remapper.sv @@
// ----------------------------------------------------------------------------
// gamepad_input_remapper
// Touch quadrant latch and button/stick remapping for controller frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : stream of items. tuser = action (0 touch, 1 frame).
//           Touch items set a quadrant bit in the zone latch, no result.
//           Frame items give one result on out_* and clear the latch.
//   out_* : remapped frame; tuser = menu_request.
//   cfg_* : APB register port, 64-bit data, register i at byte 8*i.
//           Write only while the block is idle.
// Pipeline: an accepted item is held in an input register, then the result
//   of a frame item sits in the output register until it is taken.
// Throughput: one item per cycle while no result stalls; the input register
//   and the output register each hold one item, so input keeps flowing
//   while a result waits to be taken, until a frame item queues behind it.
// Stall: with out_tready low, one result and one queued frame item are held
//   and in_tready drops; a queued touch item still drains into the latch.
// Reset: both stages empty, latch cleared, registers at default values.
// ----------------------------------------------------------------------------
module gamepad_input_remapper
  import gir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] touch_panel, [11:1] touch_x, [22:12] touch_y, [38:23] button_bits,
  // [46:39] left_x, [54:47] left_y, [62:55] right_x, [70:63] right_y,
  // [71] inverted
  input  logic [71:0] in_tdata,
  // [0] action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] buttons_out, [23:16] left_x_out, [31:24] left_y_out,
  // [39:32] right_x_out, [47:40] right_y_out
  output logic [47:0] out_tdata,
  // [0] menu_request
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t      cfg_r;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic [7:0] latch_r;
  logic [7:0] latch_nxt;
  out_item_t frame_res;
  logic      s1_adv;
  logic      out_load;
  logic      cfg_wr;
  logic [2:0] cfg_idx;
  logic [2:0] zone;

  gir_frame_map u_map (
    .item  (s1_item_r),
    .latch (latch_r),
    .cfg   (cfg_r),
    .res   (frame_res)
  );

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.remap_low  <= REMAP_LOW_RST;
      cfg_r.remap_mid  <= REMAP_MID_RST;
      cfg_r.remap_high <= REMAP_HIGH_RST;
      cfg_r.left_x_dz  <= DEADZONE_RST;
      cfg_r.left_y_dz  <= DEADZONE_RST;
      cfg_r.right_x_dz <= DEADZONE_RST;
      cfg_r.right_y_dz <= DEADZONE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REMAP_LOW:  cfg_r.remap_low  <= cfg_pwdata[59:0];
        REG_REMAP_MID:  cfg_r.remap_mid  <= cfg_pwdata[59:0];
        REG_REMAP_HIGH: cfg_r.remap_high <= cfg_pwdata[39:0];
        REG_LX_DZ:      cfg_r.left_x_dz  <= cfg_pwdata[6:0];
        REG_LY_DZ:      cfg_r.left_y_dz  <= cfg_pwdata[6:0];
        REG_RX_DZ:      cfg_r.right_x_dz <= cfg_pwdata[6:0];
        REG_RY_DZ:      cfg_r.right_y_dz <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_REMAP_LOW:  cfg_prdata = {4'b0, cfg_r.remap_low};
      REG_REMAP_MID:  cfg_prdata = {4'b0, cfg_r.remap_mid};
      REG_REMAP_HIGH: cfg_prdata = {24'b0, cfg_r.remap_high};
      REG_LX_DZ:      cfg_prdata = {57'b0, cfg_r.left_x_dz};
      REG_LY_DZ:      cfg_prdata = {57'b0, cfg_r.left_y_dz};
      REG_RX_DZ:      cfg_prdata = {57'b0, cfg_r.right_x_dz};
      REG_RY_DZ:      cfg_prdata = {57'b0, cfg_r.right_y_dz};
      default:        cfg_prdata = '0;
    endcase
  end

  // pipeline control
  assign s1_adv    = s1_valid_r && (s1_item_r.action == ACT_TOUCH || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign out_load  = s1_adv && s1_item_r.action == ACT_FRAME;
  assign zone      = {s1_item_r.touch_panel,
                      s1_item_r.touch_y > SPLIT_Y,
                      s1_item_r.touch_x > SPLIT_X};

  always_comb begin
    s1_valid_nxt  = (s1_valid_r && !s1_adv) || (in_tvalid && in_tready);
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
    latch_nxt     = latch_r;
    if (s1_adv) begin
      if (s1_item_r.action == ACT_TOUCH) begin
        latch_nxt = latch_r | (8'b1 << zone);
      end else begin
        latch_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      latch_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      latch_r     <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.action      <= in_tuser;
      s1_item_r.touch_panel <= in_tdata[0];
      s1_item_r.touch_x     <= in_tdata[11:1];
      s1_item_r.touch_y     <= in_tdata[22:12];
      s1_item_r.button_bits <= in_tdata[38:23];
      s1_item_r.left_x      <= in_tdata[46:39];
      s1_item_r.left_y      <= in_tdata[54:47];
      s1_item_r.right_x     <= in_tdata[62:55];
      s1_item_r.right_y     <= in_tdata[70:63];
      s1_item_r.inverted    <= in_tdata[71];
    end
    if (out_load) begin
      out_item_r <= frame_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_item_r.right_y_out, out_item_r.right_x_out,
                       out_item_r.left_y_out, out_item_r.left_x_out,
                       out_item_r.buttons_out};
  assign out_tuser  = out_item_r.menu_request;

`ifndef ASSERT_OFF
  a_frame_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> latch_r == '0)
    else $error("latch not cleared after frame");

  a_touch_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.action == ACT_TOUCH |=> latch_r != '0)
    else $error("touch did not set a zone bit");

  a_stall_keeps_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

  a_left_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tuser &&
    (cfg_r.remap_high[4:0] != PASS_CODE || cfg_r.remap_high[9:5] != PASS_CODE ||
     cfg_r.remap_high[14:10] != PASS_CODE || cfg_r.remap_high[19:15] != PASS_CODE)
    |-> out_tdata[23:16] == CENTER && out_tdata[31:24] == CENTER)
    else $error("left stick not centered while remapped");
`endif

endmodule
